/* src/crv_pkg.sv */
package crv_pkg;

  // Fraction bits of the fixed-point fields.
  localparam int F = 16;
  // Width of z0 (root density) and of the divisors.
  localparam int ZW = (31 + F + 1) / 2;
  // Width of the even-padded sqrt radicand.
  localparam int SW = 2 * ZW;
  // Dividend width of the quotient units; quotient bits produced.
  localparam int DW = 62;
  localparam int QW = 32;
  localparam int HW = DW - QW;
  localparam int RW = ZW + 1;
  // Quotient unit latency in pipeline stages.
  localparam int DIV_LAT = QW + 1;

  localparam logic [17:0] GAMMA_RESET = 18'd91750;
  localparam logic [17:0] GAMMA_ONE = 18'd65536;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic        sat;
    logic [31:0] value;
  } sat_res_t;

  function automatic logic [31:0] mag32(input logic [31:0] x);
    mag32 = x[31] ? 32'(-x) : x;
  endfunction

  // Applies a sign to a magnitude and clamps to the signed 32-bit range.
  function automatic sat_res_t sat32(input logic neg, input logic ovf,
                                     input logic [31:0] q);
    sat_res_t r;
    if (neg) begin
      if (ovf || q > 32'h8000_0000) begin
        r.sat = 1'b1;
        r.value = 32'h8000_0000;
      end else begin
        r.sat = 1'b0;
        r.value = 32'(-q);
      end
    end else begin
      if (ovf || q > 32'h7FFF_FFFF) begin
        r.sat = 1'b1;
        r.value = 32'h7FFF_FFFF;
      end else begin
        r.sat = 1'b0;
        r.value = q;
      end
    end
    return r;
  endfunction

endpackage

/* src/crv_div.sv */
// Pipelined restoring divider, one quotient bit per stage. The first stage
// flags quotients of 2^QW or more; only QW quotient bits are formed.
module crv_div (
  input  logic                       clk,
  input  logic                       adv,
  input  logic [crv_pkg::DW-1:0]     dividend,
  input  logic [crv_pkg::ZW-1:0]     divisor,
  output logic [crv_pkg::QW-1:0]     quotient,
  output logic                       ovf
);

  logic [crv_pkg::RW-1:0] rem_r [0:crv_pkg::QW];
  logic [crv_pkg::ZW-1:0] d_r   [0:crv_pkg::QW];
  logic [crv_pkg::QW-1:0] low_r [0:crv_pkg::QW];
  logic [crv_pkg::QW-1:0] q_r   [0:crv_pkg::QW];
  logic                   ovf_r [0:crv_pkg::QW];

  logic [crv_pkg::HW-1:0] hi;
  assign hi = dividend[crv_pkg::DW-1:crv_pkg::QW];

  always_ff @(posedge clk) begin
    if (adv) begin
      ovf_r[0] <= (hi >= crv_pkg::HW'(divisor));
      rem_r[0] <= crv_pkg::RW'(hi);
      d_r[0]   <= divisor;
      low_r[0] <= dividend[crv_pkg::QW-1:0];
      q_r[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= crv_pkg::QW; k++) begin : g_step
    logic [crv_pkg::RW-1:0] r2;
    logic                   ge;
    assign r2 = {rem_r[k-1][crv_pkg::RW-2:0], low_r[k-1][crv_pkg::QW-1]};
    assign ge = r2 >= crv_pkg::RW'(d_r[k-1]);
    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k] <= ge ? crv_pkg::RW'(r2 - crv_pkg::RW'(d_r[k-1])) : r2;
        d_r[k]   <= d_r[k-1];
        low_r[k] <= {low_r[k-1][crv_pkg::QW-2:0], 1'b0};
        q_r[k]   <= {q_r[k-1][crv_pkg::QW-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quotient = q_r[crv_pkg::QW];
  assign ovf = ovf_r[crv_pkg::QW];

endmodule

/* src/conservative_to_roe_vector_2d.sv */
// Roe parameter vector of one 2D Euler cell from its conservative variables.
// The pipeline takes one transaction per clock unless the result side stalls and
// returns one result per transaction, in order. Fields use the default Q15.16
// format. Between the edge that accepts a transaction and the rise of out_tvalid
// lie a bit-per-stage square root, two bit-per-stage divider pipelines, and the
// multiply stages between them. A stall on the result side holds the whole
// pipeline. Gamma is written through cfg_wen/cfg_wdata; the user must write it
// only while no transaction is in flight, as the block does not enforce this.
module conservative_to_roe_vector_2d (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wen,
  input  logic [17:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // density, momentum_x, momentum_y, energy (32 bits each)
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // root_density (31), scaled_velocity_x, scaled_velocity_y,
  // scaled_enthalpy (32 each), one zero pad bit
  output logic [127:0] out_tdata,
  // status
  output logic [1:0]   out_tuser
);

  localparam int ZW = crv_pkg::ZW;
  localparam int SW = crv_pkg::SW;
  localparam int F  = crv_pkg::F;
  localparam int L  = crv_pkg::DIV_LAT;
  localparam int HIW = 64 - F - 17;

  logic [17:0] gamma_r;
  logic        adv;
  logic        out_valid_r;

  assign adv = !out_valid_r || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= crv_pkg::GAMMA_RESET;
    end else if (cfg_wen) begin
      gamma_r <= cfg_wdata;
    end
  end

  // ---------------- square root stages ----------------
  logic [SW-1:0]   rad_r  [0:ZW];
  logic [ZW:0]     srem_r [0:ZW];
  logic [ZW-1:0]   root_r [0:ZW];
  logic [31:0]     smx_r  [0:ZW];
  logic [31:0]     smy_r  [0:ZW];
  logic [31:0]     sen_r  [0:ZW];
  logic            sbad_r [0:ZW];
  logic            sv_r   [0:ZW];

  logic [31:0] in_rho;
  logic        in_bad;
  assign in_rho = in_tdata[31:0];
  assign in_bad = in_rho[31] || (in_rho == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r[0] <= 1'b0;
    end else if (adv) begin
      sv_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad_r[0]  <= in_bad ? '0 : SW'({in_rho[30:0], F'(0)});
      srem_r[0] <= '0;
      root_r[0] <= '0;
      smx_r[0]  <= in_tdata[63:32];
      smy_r[0]  <= in_tdata[95:64];
      sen_r[0]  <= in_tdata[127:96];
      sbad_r[0] <= in_bad;
    end
  end

  for (genvar i = 1; i <= ZW; i++) begin : g_sqrt
    logic [ZW+2:0] rem2;
    logic [ZW+2:0] trial;
    logic          take;
    assign rem2  = {srem_r[i-1], rad_r[i-1][SW-1:SW-2]};
    assign trial = (ZW+3)'({root_r[i-1], 2'b01});
    assign take  = rem2 >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[i] <= 1'b0;
      end else if (adv) begin
        sv_r[i] <= sv_r[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[i]  <= {rad_r[i-1][SW-3:0], 2'b00};
        srem_r[i] <= take ? (ZW+1)'(rem2 - trial) : (ZW+1)'(rem2);
        root_r[i] <= {root_r[i-1][ZW-2:0], take};
        smx_r[i]  <= smx_r[i-1];
        smy_r[i]  <= smy_r[i-1];
        sen_r[i]  <= sen_r[i-1];
        sbad_r[i] <= sbad_r[i-1];
      end
    end
  end

  logic [ZW-1:0] z0;
  assign z0 = root_r[ZW];

  // ---------------- momentum quotients ----------------
  logic [crv_pkg::QW-1:0] q1, q2;
  logic                   o1, o2;

  crv_div u_div_x (
    .clk(clk), .adv(adv),
    .dividend(crv_pkg::DW'({crv_pkg::mag32(smx_r[ZW]), F'(0)})),
    .divisor(z0), .quotient(q1), .ovf(o1)
  );

  crv_div u_div_y (
    .clk(clk), .adv(adv),
    .dividend(crv_pkg::DW'({crv_pkg::mag32(smy_r[ZW]), F'(0)})),
    .divisor(z0), .quotient(q2), .ovf(o2)
  );

  logic [ZW-1:0] az0_r  [0:L-1];
  logic          anx_r  [0:L-1];
  logic          any_r  [0:L-1];
  logic [31:0]   aen_r  [0:L-1];
  logic          abad_r [0:L-1];
  logic          av_r   [0:L-1];

  for (genvar j = 0; j < L; j++) begin : g_dly1
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        av_r[j] <= 1'b0;
      end else if (adv) begin
        av_r[j] <= (j == 0) ? sv_r[ZW] : av_r[(j == 0) ? 0 : j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (j == 0) begin
          az0_r[j]  <= z0;
          anx_r[j]  <= smx_r[ZW][31];
          any_r[j]  <= smy_r[ZW][31];
          aen_r[j]  <= sen_r[ZW];
          abad_r[j] <= sbad_r[ZW];
        end else begin
          az0_r[j]  <= az0_r[(j == 0) ? 0 : j-1];
          anx_r[j]  <= anx_r[(j == 0) ? 0 : j-1];
          any_r[j]  <= any_r[(j == 0) ? 0 : j-1];
          aen_r[j]  <= aen_r[(j == 0) ? 0 : j-1];
          abad_r[j] <= abad_r[(j == 0) ? 0 : j-1];
        end
      end
    end
  end

  // ---------------- stage A: saturate z1, z2 ----------------
  crv_pkg::sat_res_t r1, r2;
  assign r1 = crv_pkg::sat32(anx_r[L-1], o1, q1);
  assign r2 = crv_pkg::sat32(any_r[L-1], o2, q2);

  logic [31:0] a_z1_r, a_z2_r, a_en_r;
  logic [ZW-1:0] a_z0_r;
  logic a_sat_r, a_bad_r, a_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_z1_r  <= r1.value;
      a_z2_r  <= r2.value;
      a_sat_r <= r1.sat || r2.sat;
      a_en_r  <= aen_r[L-1];
      a_z0_r  <= az0_r[L-1];
      a_bad_r <= abad_r[L-1];
    end
  end

  // ---------------- stage B: squares, gamma * energy ----------------
  logic [63:0] b_s1_r, b_s2_r;
  logic [49:0] b_ge_r;
  logic [31:0] b_z1_r, b_z2_r;
  logic [ZW-1:0] b_z0_r;
  logic b_eneg_r, b_sat_r, b_bad_r, b_v_r;
  logic [31:0] m1, m2;
  assign m1 = crv_pkg::mag32(a_z1_r);
  assign m2 = crv_pkg::mag32(a_z2_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      b_s1_r   <= 64'(m1) * 64'(m1);
      b_s2_r   <= 64'(m2) * 64'(m2);
      b_ge_r   <= 50'(gamma_r) * 50'(crv_pkg::mag32(a_en_r));
      b_eneg_r <= a_en_r[31];
      b_z1_r   <= a_z1_r;
      b_z2_r   <= a_z2_r;
      b_z0_r   <= a_z0_r;
      b_sat_r  <= a_sat_r;
      b_bad_r  <= a_bad_r;
    end
  end

  // ---------------- stage C: kinetic term products ----------------
  logic [63:0] sq;
  logic [63:0] sqf;
  logic [17:0] gm_mag;
  logic        gm_neg;
  assign sq = b_s1_r + b_s2_r;
  assign sqf = sq >> F;
  assign gm_neg = gamma_r < crv_pkg::GAMMA_ONE;
  assign gm_mag = gm_neg ? 18'(crv_pkg::GAMMA_ONE - gamma_r)
                         : 18'(gamma_r - crv_pkg::GAMMA_ONE);

  logic [HIW+17:0] c_phi_r;
  logic [34:0]     c_plo_r;
  logic [33:0]     c_ge_r;
  logic [31:0]     c_z1_r, c_z2_r;
  logic [ZW-1:0]   c_z0_r;
  logic c_eneg_r, c_gneg_r, c_sat_r, c_bad_r, c_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      c_phi_r  <= (HIW+18)'(gm_mag) * (HIW+18)'(sqf[HIW+16:17]);
      c_plo_r  <= 35'(gm_mag) * 35'(sqf[16:0]);
      c_ge_r   <= b_ge_r[49:16];
      c_gneg_r <= gm_neg;
      c_eneg_r <= b_eneg_r;
      c_z1_r   <= b_z1_r;
      c_z2_r   <= b_z2_r;
      c_z0_r   <= b_z0_r;
      c_sat_r  <= b_sat_r;
      c_bad_r  <= b_bad_r;
    end
  end

  // ---------------- stage D: numerator ----------------
  logic [63:0] kin, ge_s, kin_s, num;
  assign kin   = 64'(c_phi_r) + 64'(c_plo_r >> 17);
  assign ge_s  = c_eneg_r ? -64'(c_ge_r) : 64'(c_ge_r);
  assign kin_s = c_gneg_r ? -kin : kin;
  assign num   = ge_s - kin_s;

  logic [63:0]   d_mag_r;
  logic          d_neg_r;
  logic [31:0]   d_z1_r, d_z2_r;
  logic [ZW-1:0] d_z0_r;
  logic d_sat_r, d_bad_r, d_v_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      d_neg_r <= num[63];
      d_mag_r <= num[63] ? -num : num;
      d_z1_r  <= c_z1_r;
      d_z2_r  <= c_z2_r;
      d_z0_r  <= c_z0_r;
      d_sat_r <= c_sat_r;
      d_bad_r <= c_bad_r;
    end
  end

  // ---------------- enthalpy quotient ----------------
  logic huge;
  assign huge = d_mag_r >= (64'd1 << (62 - F));

  logic [crv_pkg::QW-1:0] q3;
  logic                   o3;

  crv_div u_div_h (
    .clk(clk), .adv(adv),
    .dividend(crv_pkg::DW'(d_mag_r << F)),
    .divisor(d_z0_r), .quotient(q3), .ovf(o3)
  );

  logic [ZW-1:0] ez0_r  [0:L-1];
  logic [31:0]   ez1_r  [0:L-1];
  logic [31:0]   ez2_r  [0:L-1];
  logic          eneg_r [0:L-1];
  logic          ehug_r [0:L-1];
  logic          esat_r [0:L-1];
  logic          ebad_r [0:L-1];
  logic          ev_r   [0:L-1];

  for (genvar j = 0; j < L; j++) begin : g_dly2
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ev_r[j] <= 1'b0;
      end else if (adv) begin
        ev_r[j] <= (j == 0) ? d_v_r : ev_r[(j == 0) ? 0 : j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        if (j == 0) begin
          ez0_r[j]  <= d_z0_r;
          ez1_r[j]  <= d_z1_r;
          ez2_r[j]  <= d_z2_r;
          eneg_r[j] <= d_neg_r;
          ehug_r[j] <= huge;
          esat_r[j] <= d_sat_r;
          ebad_r[j] <= d_bad_r;
        end else begin
          ez0_r[j]  <= ez0_r[(j == 0) ? 0 : j-1];
          ez1_r[j]  <= ez1_r[(j == 0) ? 0 : j-1];
          ez2_r[j]  <= ez2_r[(j == 0) ? 0 : j-1];
          eneg_r[j] <= eneg_r[(j == 0) ? 0 : j-1];
          ehug_r[j] <= ehug_r[(j == 0) ? 0 : j-1];
          esat_r[j] <= esat_r[(j == 0) ? 0 : j-1];
          ebad_r[j] <= ebad_r[(j == 0) ? 0 : j-1];
        end
      end
    end
  end

  // Valid bits of the short stages between the two quotient units.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= av_r[L-1];
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  // ---------------- output register ----------------
  crv_pkg::sat_res_t r3;
  assign r3 = crv_pkg::sat32(eneg_r[L-1], o3 || ehug_r[L-1], q3);

  logic [127:0] out_data_nxt, out_data_r;
  logic [1:0]   out_stat_nxt, out_stat_r;

  always_comb begin
    if (ebad_r[L-1]) begin
      out_data_nxt = '0;
      out_stat_nxt = crv_pkg::ST_BAD;
    end else begin
      out_data_nxt = {1'b0, r3.value, ez2_r[L-1], ez1_r[L-1], 31'(ez0_r[L-1])};
      out_stat_nxt = (esat_r[L-1] || r3.sat) ? crv_pkg::ST_SAT : crv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ev_r[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
      out_stat_r <= out_stat_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

  ap_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == crv_pkg::ST_BAD |-> out_tdata == '0)
    else $error("rejected density with nonzero result");

  ap_ok_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == crv_pkg::ST_OK |-> out_tdata[30:0] != '0)
    else $error("zero root density on a good cell");

  ap_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined status code");

  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

endmodule
